// ----- rtl/dtk_pkg.sv -----
// Shared types, constants and the insertion planning function of the outlier tracker.
`timescale 1ns / 1ps
package dtk_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = 5;
	localparam int MIN_W       = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TABLE_SIZE = 2'd0,
		REG_LONG_MIN   = 2'd1,
		REG_EFF_MIN    = 2'd2
	} cfg_reg_t;

	// Opcodes and table selectors.
	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_READ  = 1'b1;
	localparam logic TBL_LONG = 1'b0;
	localparam logic TBL_EFF  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        opcode;
		logic [63:0] blk_num;
		logic [15:0] tx_cnt;
		logic [39:0] gas_amt;
		logic [39:0] total_duration;
		logic        table_select;
		logic [3:0]  read_index;
	} req_t;

	typedef struct packed {
		logic        admitted_long;
		logic        admitted_gas;
		logic        entry_valid;
		logic [63:0] entry_blk_num;
		logic [15:0] entry_tx_cnt;
		logic [39:0] entry_gas_amt;
		logic [39:0] entry_duration;
		logic [4:0]  table_fill;
	} rsp_t;

	// One table entry as held by a cell.
	typedef struct packed {
		logic [63:0] bn;
		logic [15:0] txn;
		logic [39:0] gas;
		logic [39:0] dur;
	} entry_t;

	// Phase strobes broadcast to every cell.
	typedef struct packed {
		logic mul0;
		logic mul1;
	} cell_ctl_t;

	// Per-cell load selection.
	typedef struct packed {
		logic take_blk;
		logic take_prev;
	} load_t;

	typedef struct packed {
		logic                   admit;
		logic [FILL_W-1:0]      new_fill;
		logic [TABLE_DEPTH-1:0] take_blk;
		logic [TABLE_DEPTH-1:0] take_prev;
	} plan_t;

	// Works out admission, insertion point and new fill from the cell verdicts.
	// A set beaten bit means the new block ranks strictly ahead of that cell's entry.
	function automatic plan_t plan_insert(input logic en, input logic [FILL_W-1:0] fill,
		input logic [SIZE_W-1:0] size, input logic [TABLE_DEPTH-1:0] beaten);
		plan_t             p;
		logic [FILL_W-1:0] size_c;
		logic [FILL_W-1:0] fe;
		logic [FILL_W-1:0] fb;
		logic [FILL_W-1:0] pos;
		logic              found;
		p      = '0;
		fb     = '0;
		pos    = '0;
		found  = 1'b0;
		if (int'(size) > TABLE_DEPTH) begin
			size_c = FILL_W'(TABLE_DEPTH);
		end else begin
			size_c = FILL_W'(size);
		end
		fe         = (fill > size_c) ? size_c : fill;
		p.new_fill = fill;
		if (en && (size != '0)) begin
			p.new_fill = fe;
			if (fe == size_c) begin
				fb      = size_c - FILL_W'(1);
				p.admit = beaten[IDX_W'(fb)];
			end else begin
				p.admit = 1'b1;
				fb      = fe;
			end
			if (p.admit) begin
				pos = fb;
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (!found && (FILL_W'(i) < fb) && beaten[i]) begin
						pos   = FILL_W'(i);
						found = 1'b1;
					end
				end
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					p.take_blk[i]  = (FILL_W'(i) == pos);
					p.take_prev[i] = (FILL_W'(i) > pos) && (FILL_W'(i) <= fb);
				end
				p.new_fill = fb + FILL_W'(1);
			end
		end
		return p;
	endfunction

endpackage

// ----- rtl/dual_top_k_outlier_tracker.sv -----
// Top level of the dual outlier tracker: control, configuration, cell chains and result.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | dtk_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_stall   | dtk_pkg::rsp_t
//   cfg     | in        | cfg_we                  | cfg_index, cfg_data
//
// An offer steps through MUL0 and MUL1, where the cells form their cross products (the
// long cells in MUL0, the efficiency cells as 40 by 20 bit halves across both), UPD
// for the update and DONE, which loads the result; the next transaction is taken after
// the return to IDLE. A read goes straight to DONE, which loads its result. No clearing
// pass: reset clears the fills, not the entries. A stalled result holds the block in
// its final state; a new transaction is taken once that result is loaded.
`timescale 1ns / 1ps
module dual_top_k_outlier_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  dtk_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output dtk_pkg::rsp_t                   rsp,
	input  logic                            cfg_we,
	input  logic [dtk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dtk_pkg::CFG_W-1:0]       cfg_data
);
	import dtk_pkg::*;

	state_t            state_q, state_d;
	logic [SIZE_W-1:0] size_q;
	logic [MIN_W-1:0]  long_min_q;
	logic [MIN_W-1:0]  eff_min_q;
	req_t              blk_q;
	logic [FILL_W-1:0] long_fill_q;
	logic [FILL_W-1:0] eff_fill_q;
	logic              adm_long_q;
	logic              adm_gas_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	cell_ctl_t              ctl;
	logic                   upd;
	logic                   rsp_load;
	entry_t                 blk_e;
	entry_t                 long_e [TABLE_DEPTH];
	entry_t                 eff_e  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] long_beaten;
	logic [TABLE_DEPTH-1:0] eff_beaten;
	plan_t                  long_plan;
	plan_t                  eff_plan;
	rsp_t                   rsp_d;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= '0;
			long_min_q <= 16'd1;
			eff_min_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TABLE_SIZE: size_q     <= cfg_data[SIZE_W-1:0];
				REG_LONG_MIN:   long_min_q <= cfg_data[MIN_W-1:0];
				REG_EFF_MIN:    eff_min_q  <= cfg_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (req.opcode == OP_READ) ? ST_DONE : ST_MUL0;
				end
			end
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_UPD;
			ST_UPD:  state_d = ST_DONE;
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		ctl.mul0  = (state_q == ST_MUL0);
		ctl.mul1  = (state_q == ST_MUL1);
		upd       = (state_q == ST_UPD);
		rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the accepted transaction for the whole operation.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_valid) begin
			blk_q <= req;
		end
	end

	assign blk_e = '{bn: blk_q.blk_num, txn: blk_q.tx_cnt,
		gas: blk_q.gas_amt, dur: blk_q.total_duration};

	// Cell chains; each cell receives the entry of the cell ahead of it.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cells
		load_t long_ld;
		load_t eff_ld;
		assign long_ld.take_blk  = upd && long_plan.take_blk[i];
		assign long_ld.take_prev = upd && long_plan.take_prev[i];
		assign eff_ld.take_blk   = upd && eff_plan.take_blk[i];
		assign eff_ld.take_prev  = upd && eff_plan.take_prev[i];

		dtk_long_cell u_long (
			.clk    (clk),
			.blk    (blk_e),
			.prev   ((i == 0) ? blk_e : long_e[(i == 0) ? 0 : i - 1]),
			.ctl    (ctl),
			.ld     (long_ld),
			.entry  (long_e[i]),
			.beaten (long_beaten[i])
		);

		dtk_eff_cell u_eff (
			.clk    (clk),
			.blk    (blk_e),
			.prev   ((i == 0) ? blk_e : eff_e[(i == 0) ? 0 : i - 1]),
			.ctl    (ctl),
			.ld     (eff_ld),
			.entry  (eff_e[i]),
			.beaten (eff_beaten[i])
		);
	end

	// Insertion plans from the cell verdicts.
	assign long_plan = plan_insert(blk_q.tx_cnt >= long_min_q, long_fill_q, size_q,
		long_beaten);
	assign eff_plan  = plan_insert(blk_q.tx_cnt >= eff_min_q, eff_fill_q, size_q,
		eff_beaten);

	// Fills and admission flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_fill_q <= '0;
			eff_fill_q  <= '0;
			adm_long_q  <= 1'b0;
			adm_gas_q   <= 1'b0;
		end else if ((state_q == ST_IDLE) && req_valid) begin
			adm_long_q <= 1'b0;
			adm_gas_q  <= 1'b0;
		end else if (upd) begin
			long_fill_q <= long_plan.new_fill;
			eff_fill_q  <= eff_plan.new_fill;
			adm_long_q  <= long_plan.admit;
			adm_gas_q   <= eff_plan.admit;
		end
	end

	// Result assembly, including the entry read.
	always_comb begin
		logic [FILL_W-1:0] fill_sel;
		entry_t            rd;
		fill_sel = (blk_q.table_select == TBL_EFF) ? eff_fill_q : long_fill_q;
		rd       = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (int'(blk_q.read_index) == i) begin
				rd = (blk_q.table_select == TBL_EFF) ? eff_e[i] : long_e[i];
			end
		end
		rsp_d               = '0;
		rsp_d.admitted_long = adm_long_q;
		rsp_d.admitted_gas  = adm_gas_q;
		rsp_d.table_fill    = 5'(fill_sel);
		if ((blk_q.opcode == OP_READ) && (int'(blk_q.read_index) < int'(fill_sel))
			&& (int'(blk_q.read_index) < TABLE_DEPTH)) begin
			rsp_d.entry_valid    = 1'b1;
			rsp_d.entry_blk_num  = rd.bn;
			rsp_d.entry_tx_cnt   = rd.txn;
			rsp_d.entry_gas_amt  = rd.gas;
			rsp_d.entry_duration = rd.dur;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The fills never run past the table depth.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(long_fill_q) <= TABLE_DEPTH) && (int'(eff_fill_q) <= TABLE_DEPTH))
		else $error("table fill beyond depth");

	// Fills move only on the cycle after an update.
	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_UPD) |=> ($stable(long_fill_q) && $stable(eff_fill_q)))
		else $error("fill changed outside update");

	// A read result never reports an admission.
	a_read_no_admit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.entry_valid) |-> (!rsp.admitted_long && !rsp.admitted_gas))
		else $error("admission flagged on a read");

	// An admission always leaves the table non-empty.
	a_admit_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && long_plan.admit) |=> (long_fill_q != '0))
		else $error("admitted block left an empty table");
endmodule

// ----- rtl/dtk_long_cell.sv -----
// One cell of the time-per-transaction table: holds an entry and ranks the offered block.
`timescale 1ns / 1ps
module dtk_long_cell (
	input  logic               clk,
	input  dtk_pkg::entry_t    blk,
	input  dtk_pkg::entry_t    prev,
	input  dtk_pkg::cell_ctl_t ctl,
	input  dtk_pkg::load_t     ld,
	output dtk_pkg::entry_t    entry,
	output logic               beaten
);
	import dtk_pkg::*;

	entry_t      entry_q;
	logic [55:0] prod_w_q;
	logic [55:0] prod_b_q;
	logic [15:0] n_blk;
	logic [15:0] n_w;

	// A zero transaction count divides by one.
	assign n_blk = (blk.txn == '0) ? 16'd1 : blk.txn;
	assign n_w   = (entry_q.txn == '0) ? 16'd1 : entry_q.txn;

	// Cross products of duration and the other side's transaction count.
	always_ff @(posedge clk) begin
		if (ctl.mul0) begin
			prod_w_q <= 56'(entry_q.dur) * 56'(n_blk);
			prod_b_q <= 56'(blk.dur) * 56'(n_w);
		end
	end

	// The block wins when its duration per transaction is strictly larger.
	assign beaten = (prod_w_q < prod_b_q);

	// Take the new block or shift the neighbor's entry down by one place.
	always_ff @(posedge clk) begin
		if (ld.take_blk) begin
			entry_q <= blk;
		end else if (ld.take_prev) begin
			entry_q <= prev;
		end
	end

	assign entry = entry_q;
endmodule

// ----- rtl/dtk_eff_cell.sv -----
// One cell of the gas efficiency table: holds an entry and ranks the offered block.
`timescale 1ns / 1ps
module dtk_eff_cell (
	input  logic               clk,
	input  dtk_pkg::entry_t    blk,
	input  dtk_pkg::entry_t    prev,
	input  dtk_pkg::cell_ctl_t ctl,
	input  dtk_pkg::load_t     ld,
	output dtk_pkg::entry_t    entry,
	output logic               beaten
);
	import dtk_pkg::*;

	entry_t      entry_q;
	logic [79:0] p_q;
	logic [79:0] q_q;

	// Cross products built from two 40 by 20 bit halves: the low half in MUL0, the high half added in MUL1.
	always_ff @(posedge clk) begin
		if (ctl.mul0) begin
			p_q <= 80'(60'(entry_q.gas) * 60'(blk.dur[19:0]));
			q_q <= 80'(60'(blk.gas) * 60'(entry_q.dur[19:0]));
		end else if (ctl.mul1) begin
			p_q <= p_q + (80'(60'(entry_q.gas) * 60'(blk.dur[39:20])) << 20);
			q_q <= q_q + (80'(60'(blk.gas) * 60'(entry_q.dur[39:20])) << 20);
		end
	end

	// The block wins when its efficiency is strictly lower; zero duration is infinite.
	always_comb begin
		if ((entry_q.dur == '0) && (blk.dur != '0)) begin
			beaten = 1'b1;
		end else if ((entry_q.dur == '0) || (blk.dur == '0)) begin
			beaten = 1'b0;
		end else begin
			beaten = (p_q > q_q);
		end
	end

	// Take the new block or shift the neighbor's entry down by one place.
	always_ff @(posedge clk) begin
		if (ld.take_blk) begin
			entry_q <= blk;
		end else if (ld.take_prev) begin
			entry_q <= prev;
		end
	end

	assign entry = entry_q;
endmodule
